>>> hdl/gtp_pkg.sv
// Shared types, character codes and helpers for the GUID text parser.
`default_nettype none

package gtp_pkg;

    // Width of the character port and the number of code bits that count
    localparam int CODE_W    = 16;
    localparam int CHAR_BITS = 16;
    localparam logic [CODE_W-1:0] CHAR_MASK =
        (CHAR_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << CHAR_BITS) - 64'd1);

    // Character codes
    localparam logic [CODE_W-1:0] CH_NUL   = CODE_W'(32'h0000);
    localparam logic [CODE_W-1:0] CH_DASH  = CODE_W'(32'h002D);
    localparam logic [CODE_W-1:0] CH_SLASH = CODE_W'(32'h002F);
    localparam logic [CODE_W-1:0] CH_0     = CODE_W'(32'h0030);
    localparam logic [CODE_W-1:0] CH_9     = CODE_W'(32'h0039);
    localparam logic [CODE_W-1:0] CH_LA    = CODE_W'(32'h0061);
    localparam logic [CODE_W-1:0] CH_LF    = CODE_W'(32'h0066);
    localparam logic [CODE_W-1:0] CH_UA    = CODE_W'(32'h0041);
    localparam logic [CODE_W-1:0] CH_UF    = CODE_W'(32'h0046);

    // Digit limits per group
    localparam logic [3:0] FIRST_DIGITS = 4'd8;
    localparam logic [3:0] GROUP_DIGITS = 4'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_SEP = 2'd1;
    localparam logic [1:0] ST_NO_HEX = 2'd2;

    // Parse phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SEEK  = 4'd1,
        PH_GRP1  = 4'd2,
        PH_GRP2  = 4'd3,
        PH_GRP3  = 4'd4,
        PH_GRP4  = 4'd5,
        PH_GRP5  = 4'd6,
        PH_GRP6  = 4'd7,
        PH_GRP7  = 4'd8,
        PH_SLASH = 4'd9
    } phase_t;

    // Decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [CODE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_LA + CODE_W'(32'd10));
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_UA + CODE_W'(32'd10));
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> hdl/guid_text_parser_unit.sv
// Top level of the GUID text parser: character input register, parse step, result register.
//
// The block reads GUID text one character per transfer and sustains one character per
// clock while the result register is free or draining. A character taken in lands in an
// input register; from that register the parse step (hex decode, one group update, phase
// advance) runs into the parse state and, when the string is complete, into the result
// register. start_req marks the first character of a string and drops any parse in
// progress. The input side stalls only while a finished result waits in the result
// register and the input register is full.
// Leading non-hex text is skipped, groups of up to 8, 4, 4 and 4 hex digits each need a
// trailing '-', three more groups of 4 follow without separators, and the string ends
// at '/' (has_comment set) or NUL. guid_tail holds groups four to seven in text order,
// group four in the top bits.
`default_nettype none

module guid_text_parser_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [gtp_pkg::CODE_W-1:0] char_code,
    input  wire logic                      start_req,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [31:0]                    guid_first,
    output logic [15:0]                    guid_second,
    output logic [15:0]                    guid_third,
    output logic [63:0]                    guid_tail,
    output logic [1:0]                     status,
    output logic                           has_comment
);

    // Input register
    logic                       s1_valid_reg;
    logic [gtp_pkg::CODE_W-1:0] s1_char_reg;
    logic                       s1_start_reg;
    logic                       s1_adv;

    // Parse state
    gtp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      dc_reg, dc_next;
    logic [31:0]     acc_first_reg, acc_first_next;
    logic [15:0]     acc_second_reg, acc_second_next;
    logic [15:0]     acc_third_reg, acc_third_next;
    logic [63:0]     acc_tail_reg, acc_tail_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [15:0] third_reg, third_next;
    logic [63:0] tail_reg, tail_next;
    logic [1:0]  status_reg;
    logic        comment_reg, comment_next;

    // Step decisions
    logic [gtp_pkg::CODE_W-1:0] c;
    gtp_pkg::hex_t              hx;
    gtp_pkg::phase_t            ph;
    logic [3:0]                 dc;
    logic                       do_add;
    logic [2:0]                 add_grp;
    logic                       emit;
    logic [1:0]                 emit_st;
    logic                       emit_cmt;

    // Handshake: step the input register when the result slot is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Hold the accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg  <= char_code;
            s1_start_reg <= start_req;
        end
    end

    assign c  = s1_char_reg & gtp_pkg::CHAR_MASK;
    assign hx = gtp_pkg::hex_decode(c);

    // Next phase and digit count
    always_comb
    begin
        ph         = s1_start_reg ? gtp_pkg::PH_SEEK : phase_reg;
        dc         = s1_start_reg ? 4'd0 : dc_reg;
        phase_next = ph;
        dc_next    = dc;
        do_add     = 1'b0;
        add_grp    = 3'd0;
        emit       = 1'b0;
        emit_st    = gtp_pkg::ST_OK;
        emit_cmt   = 1'b0;
        case (ph)
            gtp_pkg::PH_IDLE:
            begin
                phase_next = gtp_pkg::PH_IDLE;
            end
            gtp_pkg::PH_SEEK:
            begin
                if (hx.ok)
                begin
                    do_add     = 1'b1;
                    add_grp    = 3'd0;
                    dc_next    = 4'd1;
                    phase_next = gtp_pkg::PH_GRP1;
                end
                else if (c == gtp_pkg::CH_NUL)
                begin
                    emit    = 1'b1;
                    emit_st = gtp_pkg::ST_NO_HEX;
                end
            end
            gtp_pkg::PH_GRP1, gtp_pkg::PH_GRP2, gtp_pkg::PH_GRP3, gtp_pkg::PH_GRP4:
            begin
                if (hx.ok && dc < ((ph == gtp_pkg::PH_GRP1) ? gtp_pkg::FIRST_DIGITS
                                                           : gtp_pkg::GROUP_DIGITS))
                begin
                    do_add  = 1'b1;
                    add_grp = 3'(ph - gtp_pkg::PH_GRP1);
                    dc_next = dc + 4'd1;
                end
                else if (c == gtp_pkg::CH_DASH)
                begin
                    phase_next = gtp_pkg::phase_t'(ph + 4'd1);
                    dc_next    = 4'd0;
                end
                else
                begin
                    emit    = 1'b1;
                    emit_st = gtp_pkg::ST_NO_SEP;
                end
            end
            gtp_pkg::PH_GRP5, gtp_pkg::PH_GRP6, gtp_pkg::PH_GRP7:
            begin
                if (hx.ok && dc < gtp_pkg::GROUP_DIGITS)
                begin
                    do_add  = 1'b1;
                    add_grp = 3'(ph - gtp_pkg::PH_GRP1);
                    dc_next = dc + 4'd1;
                end
                else if (hx.ok && ph != gtp_pkg::PH_GRP7)
                begin
                    // full group: digit opens the next one
                    do_add     = 1'b1;
                    add_grp    = 3'(ph - gtp_pkg::PH_GRP1 + 4'd1);
                    dc_next    = 4'd1;
                    phase_next = gtp_pkg::phase_t'(ph + 4'd1);
                end
                else if (hx.ok)
                begin
                    phase_next = gtp_pkg::PH_SLASH;
                    dc_next    = 4'd0;
                end
                else if (c == gtp_pkg::CH_SLASH)
                begin
                    emit     = 1'b1;
                    emit_cmt = 1'b1;
                end
                else if (c == gtp_pkg::CH_NUL)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    // non-hex closes every remaining group
                    phase_next = gtp_pkg::PH_SLASH;
                    dc_next    = 4'd0;
                end
            end
            gtp_pkg::PH_SLASH:
            begin
                if (c == gtp_pkg::CH_SLASH)
                begin
                    emit     = 1'b1;
                    emit_cmt = 1'b1;
                end
                else if (c == gtp_pkg::CH_NUL)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = gtp_pkg::PH_IDLE;
            end
        endcase
        if (emit)
        begin
            phase_next = gtp_pkg::PH_IDLE;
            dc_next    = 4'd0;
        end
    end

    // Shift the digit into its group
    always_comb
    begin
        acc_first_next  = s1_start_reg ? 32'd0 : acc_first_reg;
        acc_second_next = s1_start_reg ? 16'd0 : acc_second_reg;
        acc_third_next  = s1_start_reg ? 16'd0 : acc_third_reg;
        acc_tail_next   = s1_start_reg ? 64'd0 : acc_tail_reg;
        if (do_add)
        begin
            case (add_grp)
                3'd0:    acc_first_next        = {acc_first_next[27:0], hx.val};
                3'd1:    acc_second_next       = {acc_second_next[11:0], hx.val};
                3'd2:    acc_third_next        = {acc_third_next[11:0], hx.val};
                3'd3:    acc_tail_next[63:48]  = {acc_tail_next[59:48], hx.val};
                3'd4:    acc_tail_next[47:32]  = {acc_tail_next[43:32], hx.val};
                3'd5:    acc_tail_next[31:16]  = {acc_tail_next[27:16], hx.val};
                3'd6:    acc_tail_next[15:0]   = {acc_tail_next[11:0], hx.val};
                default: acc_tail_next         = acc_tail_next;
            endcase
        end
    end

    // Form the result payload; failed parses give zero fields
    always_comb
    begin
        if (emit_st == gtp_pkg::ST_OK)
        begin
            first_next   = acc_first_next;
            second_next  = acc_second_next;
            third_next   = acc_third_next;
            tail_next    = acc_tail_next;
            comment_next = emit_cmt;
        end
        else
        begin
            first_next   = 32'd0;
            second_next  = 16'd0;
            third_next   = 16'd0;
            tail_next    = 64'd0;
            comment_next = 1'b0;
        end
    end

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= gtp_pkg::PH_IDLE;
            dc_reg         <= 4'd0;
            acc_first_reg  <= 32'd0;
            acc_second_reg <= 16'd0;
            acc_third_reg  <= 16'd0;
            acc_tail_reg   <= 64'd0;
        end
        else if (s1_adv)
        begin
            phase_reg      <= phase_next;
            dc_reg         <= dc_next;
            acc_first_reg  <= acc_first_next;
            acc_second_reg <= acc_second_next;
            acc_third_reg  <= acc_third_next;
            acc_tail_reg   <= acc_tail_next;
        end
    end

    // Result valid: load on a finished parse, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            first_reg   <= first_next;
            second_reg  <= second_next;
            third_reg   <= third_next;
            tail_reg    <= tail_next;
            status_reg  <= emit_st;
            comment_reg <= comment_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign guid_first  = first_reg;
    assign guid_second = second_reg;
    assign guid_third  = third_reg;
    assign guid_tail   = tail_reg;
    assign status      = status_reg;
    assign has_comment = comment_reg;

    // Checks
    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && emit) |=> (phase_reg == gtp_pkg::PH_IDLE))
        else $error("parser not idle after a result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == gtp_pkg::ST_OK || status_reg == gtp_pkg::ST_NO_SEP
                           || status_reg == gtp_pkg::ST_NO_HEX))
        else $error("result status out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != gtp_pkg::ST_OK) |->
        (first_reg == 32'd0 && tail_reg == 64'd0 && !comment_reg))
        else $error("failed parse carries nonzero fields");

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != gtp_pkg::PH_GRP1) |-> (dc_reg <= gtp_pkg::GROUP_DIGITS))
        else $error("group digit count over limit");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result slot");

endmodule

`default_nettype wire
